// ===== design/led_color_effect_generator_unit_macros.svh =====
// Assertion macros shared by the LED colour effect generator RTL.
// Every macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LED_COLOR_EFFECT_GENERATOR_UNIT_MACROS_SVH
`define LED_COLOR_EFFECT_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define LCEG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define LCEG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lceg_pkg.sv =====
// Shared types, command codes and constant colour tables for the LED colour effect generator.
// Used by lceg_step_phase and led_color_effect_generator_unit; depends on nothing.
package lceg_pkg;

    localparam int PALETTE_SIZE = 141;
    localparam int FADE_SIZE    = 256;

    localparam logic [7:0] CMD_RANDOM  = 8'd141;
    localparam logic [7:0] CMD_RAINBOW = 8'd142;
    localparam logic [7:0] CMD_FIRE    = 8'd143;
    localparam logic [7:0] CMD_GALAXY  = 8'd144;

    localparam logic [9:0] ROLL_SLOW_WHITE = 10'd0;
    localparam logic [9:0] ROLL_FAST_WHITE = 10'd1;
    localparam logic [9:0] ROLL_SLOW_BLUE  = 10'd2;
    localparam logic [9:0] ROLL_FAST_BLUE  = 10'd3;

    localparam logic [7:0] STAR_SLOW = 8'd1;
    localparam logic [7:0] STAR_FAST = 8'd3;
    localparam logic [7:0] FIRE_BASE = 8'd127;

    localparam logic [8:0] HUE_FULL = 9'd360;
    localparam logic [8:0] HUE_SEG  = 9'd60;
    localparam logic [3:0] TICK_PERIOD = 4'd10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lceg_rgb_t;

    // Step-derived values: position on the hue wheel and the galaxy cadence flag.
    typedef struct packed {
        logic [8:0] hue_angle;
        logic       galaxy_tick;
    } lceg_phase_t;

    localparam logic [23:0] PALETTE [PALETTE_SIZE] = '{
        24'h000000, 24'h000080, 24'h00008B, 24'h0000CD, 24'h0000FF, 24'h006400, 24'h008000,
        24'h008080, 24'h008B8B, 24'h00BFFF, 24'h00CED1, 24'h00FA9A, 24'h00FF00, 24'h00FF7F,
        24'h00FFFF, 24'h00FFFF, 24'h191970, 24'h1E90FF, 24'h20B2AA, 24'h228B22, 24'h2E8B57,
        24'h2F4F4F, 24'h32CD32, 24'h3CB371, 24'h40E0D0, 24'h4169E1, 24'h4682B4, 24'h483D8B,
        24'h48D1CC, 24'h4B0082, 24'h556B2F, 24'h5F9EA0, 24'h6495ED, 24'h663399, 24'h66CDAA,
        24'h696969, 24'h6A5ACD, 24'h6B8E23, 24'h708090, 24'h778899, 24'h7B68EE, 24'h7CFC00,
        24'h7FFF00, 24'h7FFFD4, 24'h800000, 24'h800080, 24'h808000, 24'h808080, 24'h87CEEB,
        24'h87CEFA, 24'h8A2BE2, 24'h8B0000, 24'h8B008B, 24'h8B4513, 24'h8FBC8F, 24'h90EE90,
        24'h9370DB, 24'h9400D3, 24'h98FB98, 24'h9932CC, 24'h9ACD32, 24'hA0522D, 24'hA52A2A,
        24'hA9A9A9, 24'hADD8E6, 24'hADFF2F, 24'hAFEEEE, 24'hB0C4DE, 24'hB0E0E6, 24'hB22222,
        24'hB8860B, 24'hBA55D3, 24'hBC8F8F, 24'hBDB76B, 24'hC0C0C0, 24'hC71585, 24'hCD5C5C,
        24'hCD853F, 24'hD2691E, 24'hD2B48C, 24'hD3D3D3, 24'hD8BFD8, 24'hDA70D6, 24'hDAA520,
        24'hDB7093, 24'hDC143C, 24'hDCDCDC, 24'hDDA0DD, 24'hDEB887, 24'hE0FFFF, 24'hE6E6FA,
        24'hE9967A, 24'hEE82EE, 24'hEEE8AA, 24'hF08080, 24'hF0E68C, 24'hF0F8FF, 24'hF0FFF0,
        24'hF0FFFF, 24'hF4A460, 24'hF5DEB3, 24'hF5F5DC, 24'hF5F5F5, 24'hF5FFFA, 24'hF8F8FF,
        24'hFA8072, 24'hFAEBD7, 24'hFAF0E6, 24'hFAFAD2, 24'hFDF5E6, 24'hFF0000, 24'hFF00FF,
        24'hFF00FF, 24'hFF1493, 24'hFF4500, 24'hFF6347, 24'hFF69B4, 24'hFF7F50, 24'hFF8C00,
        24'hFFA07A, 24'hFFA500, 24'hFFB6C1, 24'hFFC0CB, 24'hFFD700, 24'hFFDAB9, 24'hFFDEAD,
        24'hFFE4B5, 24'hFFE4C4, 24'hFFE4E1, 24'hFFEBCD, 24'hFFEFD5, 24'hFFF0F5, 24'hFFF5EE,
        24'hFFF8DC, 24'hFFFACD, 24'hFFFAF0, 24'hFFFAFA, 24'hFFFF00, 24'hFFFFE0, 24'hFFFFF0,
        24'hFFFFFF
    };

    localparam logic [7:0] FADE [FADE_SIZE] = '{
          8'd0,   8'd5,   8'd0,   8'd7,   8'd0,   8'd9,   8'd2,  8'd17,   8'd4,  8'd14,
          8'd6, 8'd196,   8'd4,   8'd4,  8'd20,  8'd10,   8'd8,  8'd35,   8'd8,   8'd8,
         8'd30,  8'd15,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,
         8'd40,  8'd21,   8'd8,   8'd8,   8'd8,  8'd55,  8'd18,  8'd18,  8'd18,  8'd18,
         8'd50,  8'd31,  8'd18,  8'd18,  8'd18,  8'd18,  8'd18,  8'd18,  8'd18,  8'd18,
         8'd60,  8'd41,  8'd18,  8'd18,  8'd18,  8'd75,  8'd36,  8'd36,  8'd36,  8'd36,
         8'd70,  8'd51,  8'd36,  8'd36,  8'd36,  8'd36,  8'd36,  8'd36,  8'd36,  8'd36,
         8'd80,  8'd61,  8'd36,  8'd36,  8'd36,  8'd95,  8'd56,  8'd56,  8'd56,  8'd56,
         8'd90,  8'd71,  8'd56,  8'd56,  8'd56,  8'd56,  8'd56,  8'd56,  8'd56,  8'd56,
        8'd100,  8'd81,  8'd56,  8'd56,  8'd56, 8'd115,  8'd76,  8'd76,  8'd76,  8'd76,
        8'd110,  8'd91,  8'd76,  8'd76,  8'd76,  8'd76,  8'd76,  8'd76,  8'd76,  8'd76,
        8'd120, 8'd101,  8'd76,  8'd76,  8'd76, 8'd135,  8'd96,  8'd96,  8'd96,  8'd96,
        8'd130, 8'd111,  8'd96,  8'd96,  8'd96,  8'd96,  8'd96,  8'd96,  8'd96,  8'd96,
        8'd140, 8'd121,  8'd96,  8'd96,  8'd96, 8'd155, 8'd116, 8'd116, 8'd116, 8'd116,
        8'd150, 8'd131, 8'd116, 8'd116, 8'd116, 8'd116, 8'd116, 8'd116, 8'd116, 8'd116,
        8'd160, 8'd141, 8'd116, 8'd116, 8'd116, 8'd175, 8'd136, 8'd136, 8'd136, 8'd136,
        8'd170, 8'd151, 8'd136, 8'd136, 8'd136, 8'd136, 8'd136, 8'd136, 8'd136, 8'd136,
        8'd180, 8'd161, 8'd136, 8'd136, 8'd136, 8'd195, 8'd156, 8'd156, 8'd156, 8'd156,
        8'd190, 8'd171, 8'd156, 8'd156, 8'd156, 8'd156, 8'd156, 8'd156, 8'd156, 8'd156,
        8'd200, 8'd181, 8'd156, 8'd156, 8'd156, 8'd215, 8'd176, 8'd176, 8'd176, 8'd176,
        8'd210, 8'd191, 8'd176, 8'd176, 8'd176, 8'd176, 8'd176, 8'd176, 8'd176, 8'd176,
        8'd220, 8'd201, 8'd176, 8'd176, 8'd176, 8'd235, 8'd196, 8'd196, 8'd196, 8'd196,
        8'd230, 8'd211, 8'd196, 8'd196, 8'd196, 8'd196, 8'd196, 8'd196, 8'd196, 8'd196,
        8'd240, 8'd221, 8'd196, 8'd196, 8'd196, 8'd252, 8'd216, 8'd216, 8'd216, 8'd216,
        8'd250, 8'd231, 8'd216, 8'd216, 8'd216, 8'd216, 8'd216, 8'd216, 8'd216, 8'd216,
        8'd254, 8'd241, 8'd253, 8'd236, 8'd255, 8'd251
    };

endpackage

// ===== design/lceg_step_phase.sv =====
// Three-stage reduction of the 32-bit step count to hue angle (step mod 360) and tick flag.
// Uses lceg_pkg; the caller advances all stages together through en.
module lceg_step_phase (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [31:0]          step,
    output lceg_pkg::lceg_phase_t phase
);
    import lceg_pkg::*;

    // ceil(2^26 / 360) and ceil(2^16 / 10); exact for the reduced operand ranges below
    localparam logic [17:0] RECIP_360 = 18'd186414;
    localparam logic [12:0] RECIP_10  = 13'd6554;

    logic [16:0] s360_reg, s360_next, s360_d_reg;
    logic [12:0] s10_reg, s10_next, s10_d_reg;
    logic [34:0] prod360;
    logic [25:0] prod10;
    logic [8:0]  q360_reg;
    logic [8:0]  q10_reg;
    logic [16:0] rem360;
    logic [12:0] rem10;
    lceg_phase_t phase_reg, phase_next;

    // Fold the bytes: 2^8, 2^16, 2^24 are 256, 16, 136 mod 360 and 6, 6, 6 mod 10.
    always_comb begin
        s360_next = 17'(step[7:0]) + {1'b0, step[15:8], 8'h00}
                  + 17'({step[23:16], 4'h0}) + 17'(step[31:24]) * 17'd136;
        s10_next  = 13'(step[7:0])
                  + 13'd6 * (13'(step[15:8]) + 13'(step[23:16]) + 13'(step[31:24]));
    end

    assign prod360 = 35'(s360_reg) * 35'(RECIP_360);
    assign prod10  = 26'(s10_reg) * 26'(RECIP_10);

    always_comb begin
        rem360 = s360_d_reg - 17'(q360_reg) * 17'(HUE_FULL);
        rem10  = s10_d_reg - 13'(q10_reg) * 13'(TICK_PERIOD);
        phase_next.hue_angle   = rem360[8:0];
        phase_next.galaxy_tick = (rem10 == 13'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s360_reg   <= s360_next;
            s10_reg    <= s10_next;
            q360_reg   <= prod360[34:26];
            q10_reg    <= prod10[24:16];
            s360_d_reg <= s360_reg;
            s10_d_reg  <= s10_reg;
            phase_reg  <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== design/led_color_effect_generator_unit.sv =====
// LED color effect generator: one pixel in, one new pixel color out.
// Streaming input and output channels; a five-stage pipeline with valid bits.
// Uses the lceg_pkg tables and lceg_step_phase for the step arithmetic.
//
// Input: each s_ transaction carries a color command, a step count, the pixel's
// current color, three random bytes and a star roll. Output: each m_ transaction
// carries the new color in m_tdata and the unknown-command flag in m_tuser.
// An accepted item passes v1_reg, v2_reg, v3_reg and v4_reg, then sets m_tvalid_reg.
// Throughput is one pixel per clock when not stalled; the step reduction is set
// by the mod-360 reciprocal multiply, registered between byte folding, multiply
// and remainder, and the palette, fire and galaxy colors are formed while that runs.
// All stages move together: when m_tvalid is high and m_tready is low the whole
// pipeline holds and s_tready drops in the same cycle, so nothing is lost or
// repeated. Bubbles fill in as soon as the result is taken.
// A synchronous low aresetn clears every valid bit and holds s_tready low; the data
// registers are not reset, and data is accepted as soon as reset is released.
`include "led_color_effect_generator_unit_macros.svh"

module led_color_effect_generator_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[7:0], step[39:8], current_red[47:40], current_green[55:48],
    // current_blue[63:56], rand_red[71:64], rand_green[79:72], rand_blue[87:80],
    // star_roll[97:88], zero fill [103:98]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0]  m_tdata,
    // bad_command[0]
    output logic [0:0]   m_tuser
);
    import lceg_pkg::*;

    logic en;

    // stage 1: captured item
    logic       v1_reg;
    logic [7:0] cmd1_reg;
    lceg_rgb_t  cur1_reg, rnd1_reg;
    logic [9:0] roll1_reg;

    // stage 2: held while the step is reduced
    logic       v2_reg;
    logic [7:0] cmd2_reg;
    lceg_rgb_t  cur2_reg, rnd2_reg;
    logic [9:0] roll2_reg;

    // stage 3: candidate colors
    logic        v3_reg;
    lceg_rgb_t   alt3_reg, alt3_next;
    lceg_rgb_t   cur3_reg;
    logic        bad3_reg, bad3_next;
    logic        rainbow3_reg, galaxy3_reg;
    lceg_phase_t phase;

    // stage 4: hue segment
    logic       v4_reg;
    lceg_rgb_t  alt4_reg, alt4_next;
    logic       bad4_reg, rainbow4_reg;
    logic [2:0] seg4_reg, seg4_next;
    logic [5:0] d4_reg, d4_next;

    // stage 5: output
    logic       m_tvalid_reg;
    lceg_rgb_t  out_reg, out_next;
    logic       bad_reg;

    logic [9:0] up_wide;
    logic [7:0] up, down;
    lceg_rgb_t  hue_rgb;

    logic [7:0] fire_mod, fire_red, fire_cand, fire_lim;
    logic [9:0] fire_red3;
    logic [7:0] fade_blue;
    logic       dark;
    lceg_rgb_t  galaxy_rgb;

    assign en       = !m_tvalid_reg || m_tready;
    // refuse transactions during reset; stage one would drop them
    assign s_tready = en && aresetn;

    lceg_step_phase u_phase (
        .aclk  (aclk),
        .en    (en),
        .step  (s_tdata[39:8]),
        .phase (phase)
    );

    // Fire and galaxy candidates from stage 2 fields, then alt3 and bad3 by command.
    always_comb begin
        if (rnd2_reg.red >= 8'd254) begin
            fire_mod = rnd2_reg.red - 8'd254;
        end else if (rnd2_reg.red >= FIRE_BASE) begin
            fire_mod = rnd2_reg.red - FIRE_BASE;
        end else begin
            fire_mod = rnd2_reg.red;
        end
        fire_red  = FIRE_BASE + fire_mod;
        fire_red3 = 10'(fire_red) * 10'd3;
        fire_lim  = fire_red3[9:2];
        fire_cand = (rnd2_reg.green == 8'hFF) ? 8'h00 : rnd2_reg.green;

        fade_blue  = FADE[cur2_reg.blue];
        dark       = (cur2_reg.red == 8'h00) && (cur2_reg.green == 8'h00)
                  && (cur2_reg.blue == 8'h00);
        galaxy_rgb = cur2_reg;
        if (dark) begin
            unique case (roll2_reg)
                ROLL_SLOW_WHITE: galaxy_rgb = '{STAR_SLOW, STAR_SLOW, STAR_SLOW};
                ROLL_FAST_WHITE: galaxy_rgb = '{STAR_FAST, STAR_FAST, STAR_FAST};
                ROLL_SLOW_BLUE:  galaxy_rgb = '{8'h00, 8'h00, STAR_SLOW};
                ROLL_FAST_BLUE:  galaxy_rgb = '{8'h00, 8'h00, STAR_FAST};
                default:         galaxy_rgb = cur2_reg;
            endcase
        end else begin
            galaxy_rgb.blue = fade_blue;
            if (cur2_reg.red != 8'h00) begin
                galaxy_rgb.red   = fade_blue;
                galaxy_rgb.green = fade_blue;
            end
        end

        bad3_next = 1'b0;
        if (cmd2_reg < 8'(PALETTE_SIZE)) begin
            alt3_next = PALETTE[cmd2_reg];
        end else if (cmd2_reg == CMD_RANDOM) begin
            alt3_next = rnd2_reg;
        end else if (cmd2_reg == CMD_FIRE) begin
            alt3_next = '{fire_red, (fire_cand < fire_lim) ? fire_cand : fire_lim, 8'h00};
        end else if (cmd2_reg == CMD_GALAXY) begin
            alt3_next = galaxy_rgb;
        end else if (cmd2_reg == CMD_RAINBOW) begin
            alt3_next = cur2_reg;
        end else begin
            alt3_next = cur2_reg;
            bad3_next = 1'b1;
        end
    end

    // Galaxy only changes the pixel on a tick; split the angle into segment and offset.
    always_comb begin
        alt4_next = (galaxy3_reg && !phase.galaxy_tick) ? cur3_reg : alt3_reg;
        if (phase.hue_angle >= 9'd300) begin
            seg4_next = 3'd5;
            d4_next   = 6'(phase.hue_angle - 9'd300);
        end else if (phase.hue_angle >= 9'd240) begin
            seg4_next = 3'd4;
            d4_next   = 6'(phase.hue_angle - 9'd240);
        end else if (phase.hue_angle >= 9'd180) begin
            seg4_next = 3'd3;
            d4_next   = 6'(phase.hue_angle - 9'd180);
        end else if (phase.hue_angle >= 9'd120) begin
            seg4_next = 3'd2;
            d4_next   = 6'(phase.hue_angle - 9'd120);
        end else if (phase.hue_angle >= HUE_SEG) begin
            seg4_next = 3'd1;
            d4_next   = 6'(phase.hue_angle - HUE_SEG);
        end else begin
            seg4_next = 3'd0;
            d4_next   = 6'(phase.hue_angle);
        end
    end

    // 255/60 is 17/4, so the ramp is a shift-add.
    always_comb begin
        up_wide = 10'(d4_reg) * 10'd17;
        up      = up_wide[9:2];
        down    = 8'hFF - up;
        unique case (seg4_reg)
            3'd0:    hue_rgb = '{8'hFF, up,    8'h00};
            3'd1:    hue_rgb = '{down,  8'hFF, 8'h00};
            3'd2:    hue_rgb = '{8'h00, 8'hFF, up};
            3'd3:    hue_rgb = '{8'h00, down,  8'hFF};
            3'd4:    hue_rgb = '{up,    8'h00, 8'hFF};
            default: hue_rgb = '{8'hFF, 8'h00, down};
        endcase
        out_next = rainbow4_reg ? hue_rgb : alt4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg     <= s_tdata[7:0];
            cur1_reg     <= '{s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
            rnd1_reg     <= '{s_tdata[71:64], s_tdata[79:72], s_tdata[87:80]};
            roll1_reg    <= s_tdata[97:88];

            cmd2_reg     <= cmd1_reg;
            cur2_reg     <= cur1_reg;
            rnd2_reg     <= rnd1_reg;
            roll2_reg    <= roll1_reg;

            alt3_reg     <= alt3_next;
            cur3_reg     <= cur2_reg;
            bad3_reg     <= bad3_next;
            rainbow3_reg <= (cmd2_reg == CMD_RAINBOW);
            galaxy3_reg  <= (cmd2_reg == CMD_GALAXY);

            alt4_reg     <= alt4_next;
            bad4_reg     <= bad3_reg;
            rainbow4_reg <= rainbow3_reg;
            seg4_reg     <= seg4_next;
            d4_reg       <= d4_next;

            out_reg      <= out_next;
            bad_reg      <= bad4_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red};
    assign m_tuser  = bad_reg;

    `LCEG_ASSERT_IMP(a_hue_angle_range, v3_reg, phase.hue_angle < HUE_FULL,
        "hue angle out of range")
    `LCEG_ASSERT_IMP(a_hue_offset_range, v4_reg, (d4_reg < 6'd60) && (seg4_reg <= 3'd5),
        "hue segment offset out of range")
    `LCEG_ASSERT_NXT(a_accept_enters_pipe, s_tvalid && s_tready, v1_reg,
        "accepted transaction did not enter stage one")

endmodule
